/* design/env_sensor_compensation_top_assert.svh */
// Assertion macros for the sensor compensation block.
// Needs i_clk and i_rst_n in the scope of the including module.
`ifndef ENV_SENSOR_COMPENSATION_TOP_ASSERT_SVH
`define ENV_SENSOR_COMPENSATION_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define ESC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define ESC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/esc_pkg.sv */
// Types, constants and arithmetic helpers for the sensor compensation block.
// No dependencies.
`timescale 1ns / 1ps
package esc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEMP       = 3'd0,
        REG_PRESS_LOW  = 3'd1,
        REG_PRESS_MID  = 3'd2,
        REG_PRESS_LAST = 3'd3,
        REG_HUM        = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [19:0] raw_pressure;
        logic [19:0] raw_temperature;
        logic [15:0] raw_humidity;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] temperature_centi;
        logic [31:0]        pressure_scaled;
        logic [16:0]        humidity_q10;
    } t_out_word;

    // pipeline depth: front end, one stage per quotient bit, back end
    localparam int NUM_FRONT = 14;
    localparam int DIV_STEPS = 64;
    localparam int NUM_BACK  = 6;
    localparam int NUM_STG   = NUM_FRONT + DIV_STEPS + NUM_BACK;

    localparam logic [31:0] HUM_MAX = 32'd419430400;

    // 64x64 mod 2^64 product split into 32x32 partials
    typedef struct packed {
        logic [63:0] ll;
        logic [31:0] cr;
    } t_pp;

    typedef struct packed {
        logic [19:0] rp;
        logic [15:0] rh;
        logic [31:0] temp;
        logic [16:0] hum;
    } t_fsb;

    typedef struct packed {
        logic [31:0] temp;
        logic [16:0] hum;
        logic        neg;
        logic        zero;
        logic [30:0] ad;
    } t_dsb;

    typedef struct packed {
        logic [30:0] rem;
        logic [63:0] q;
    } t_dv;

    typedef struct packed {
        logic [31:0] temp;
        logic [16:0] hum;
        logic        zero;
    } t_bsb;

    function automatic logic [31:0] f_asr32(input logic [31:0] x, input logic [5:0] sh);
        return 32'($signed(x) >>> sh);
    endfunction

    function automatic logic [63:0] f_asr64(input logic [63:0] x, input logic [5:0] sh);
        return 64'($signed(x) >>> sh);
    endfunction

    function automatic t_pp f_pp(input logic [63:0] a, input logic [63:0] b);
        t_pp         r;
        logic [31:0] c1;
        logic [31:0] c2;
        r.ll = 64'(a[31:0]) * 64'(b[31:0]);
        c1   = a[31:0] * b[63:32];
        c2   = a[63:32] * b[31:0];
        r.cr = c1 + c2;
        return r;
    endfunction

    function automatic logic [63:0] f_pp_sum(input t_pp p);
        return p.ll + {p.cr, 32'd0};
    endfunction

    // one restoring step: shift in the next numerator bit, subtract if it fits
    function automatic t_dv f_div_step(input logic [30:0] rem, input logic [63:0] q,
                                       input logic [30:0] ad);
        t_dv         r;
        logic [31:0] t;
        t = {rem, q[63]};
        if (t >= {1'b0, ad}) begin
            r.rem = 31'(t - {1'b0, ad});
            r.q   = {q[62:0], 1'b1};
        end else begin
            r.rem = t[30:0];
            r.q   = {q[62:0], 1'b0};
        end
        return r;
    endfunction

endpackage

/* design/env_sensor_compensation_top.sv */
// Throughput: one word per cycle while o_in_stall is low; the 64-stage quotient
// pipeline (one bit a stage) sets the depth, all other stages hold at most one
// multiply level each.
// Reset (i_rst_n low, synchronous): clears stage valids, output/skid valids and all
// coefficient registers to zero. Stage, output and skid payloads are not reset.
`timescale 1ns / 1ps
`include "env_sensor_compensation_top_assert.svh"
module env_sensor_compensation_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input words
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  esc_pkg::t_in_word                    i_in_word,
    // result words
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output esc_pkg::t_out_word                   o_out_word,
    // coefficient writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [esc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [esc_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import esc_pkg::*;

    localparam int LAST = NUM_STG - 1;

    // ---------------- coefficient registers ----------------
    logic [47:0] r_temp_c;
    logic [63:0] r_plo_c;
    logic [63:0] r_pmid_c;
    logic [15:0] r_plast_c;
    logic [63:0] r_hum_c;

    // unpacked coefficients, extended to the path width
    logic [31:0] w_t1, w_t2, w_t3;
    logic [31:0] w_h1, w_h2, w_h3, w_h4, w_h5, w_h6;
    logic [63:0] w_p1, w_p2, w_p3, w_p4, w_p5, w_p6, w_p7, w_p8, w_p9;

    assign w_t1 = 32'(r_temp_c[15:0]);
    assign w_t2 = 32'($signed(r_temp_c[31:16]));
    assign w_t3 = 32'($signed(r_temp_c[47:32]));

    assign w_p1 = 64'(r_plo_c[15:0]);
    assign w_p2 = 64'($signed(r_plo_c[31:16]));
    assign w_p3 = 64'($signed(r_plo_c[47:32]));
    assign w_p4 = 64'($signed(r_plo_c[63:48]));
    assign w_p5 = 64'($signed(r_pmid_c[15:0]));
    assign w_p6 = 64'($signed(r_pmid_c[31:16]));
    assign w_p7 = 64'($signed(r_pmid_c[47:32]));
    assign w_p8 = 64'($signed(r_pmid_c[63:48]));
    assign w_p9 = 64'($signed(r_plast_c));

    assign w_h1 = 32'(r_hum_c[7:0]);
    assign w_h2 = 32'($signed(r_hum_c[23:8]));
    assign w_h3 = 32'(r_hum_c[31:24]);
    assign w_h4 = 32'($signed(r_hum_c[43:32]));
    assign w_h5 = 32'($signed(r_hum_c[55:44]));
    assign w_h6 = 32'($signed(r_hum_c[63:56]));

    // writes are always accepted
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_c  <= '0;
            r_plo_c   <= '0;
            r_pmid_c  <= '0;
            r_plast_c <= '0;
            r_hum_c   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                REG_TEMP:       r_temp_c  <= i_cfg_data[47:0];
                REG_PRESS_LOW:  r_plo_c   <= i_cfg_data;
                REG_PRESS_MID:  r_pmid_c  <= i_cfg_data;
                REG_PRESS_LAST: r_plast_c <= i_cfg_data[15:0];
                REG_HUM:        r_hum_c   <= i_cfg_data;
                default: ;      // unused indexes are dropped
            endcase
        end
    end

    // ---------------- flow control ----------------
    // The whole pipe moves together while the skid slot is free. The output
    // word plus one skid word decouple the pipe from the consumer, so a new
    // word is still taken in the cycle the first result gets stalled.
    logic [NUM_STG-1:0] r_vld, n_vld;
    logic               r_out_v, n_out_v;
    logic               r_skid_v, n_skid_v;
    t_out_word          r_out, n_out;
    t_out_word          r_skid, n_skid;
    t_out_word          w_res;
    logic               w_en;

    assign w_en       = !r_skid_v;
    assign o_in_stall = r_skid_v;
    assign n_vld      = w_en ? {r_vld[NUM_STG-2:0], i_in_valid} : r_vld;

    // ---------------- front end: temperature, humidity, divide operands ----------------
    t_fsb r_fsb [NUM_FRONT];
    t_fsb n_fsb [NUM_FRONT];

    logic [31:0] r1_a, n1_a, r1_dt, n1_dt;
    logic [31:0] r2_ma, n2_ma, r2_mdt, n2_mdt;
    logic [31:0] r3_va, n3_va, r3_m2, n3_m2;
    logic [31:0] r4_tf, n4_tf;
    logic [31:0] r5_v, n5_v;
    logic [63:0] r5_x1, n5_x1;
    logic [31:0] r6_ha, n6_ha, r6_m6, n6_m6, r6_m3, n6_m3;
    t_pp         r6_sq, n6_sq, r6_a5, n6_a5, r6_a2, n6_a2;
    logic [31:0] r7_ha, n7_ha, r7_hbm, n7_hbm;
    logic [63:0] r7_sq, n7_sq, r7_a5, n7_a5, r7_a2, n7_a2;
    logic [31:0] r8_ha, n8_ha, r8_hcm, n8_hcm;
    t_pp         r8_b6, n8_b6, r8_b3, n8_b3;
    logic [63:0] r8_a5, n8_a5, r8_a2, n8_a2;
    logic [31:0] r9_vv, n9_vv;
    logic [63:0] r9_b6, n9_b6, r9_b3, n9_b3, r9_a5, n9_a5, r9_a2, n9_a2;
    logic [31:0] r10_vv, n10_vv, r10_sq, n10_sq;
    logic [63:0] r10_x2, n10_x2, r10_y, n10_y;
    logic [31:0] r11_vv, n11_vv, r11_m, n11_m;
    t_pp         r11_py, n11_py;
    logic [63:0] r11_n0, n11_n0;
    logic [31:0] r12_den, n12_den;
    t_pp         r12_pn, n12_pn;
    logic [31:0] r13_den, n13_den;
    logic [63:0] r13_num, n13_num;
    logic [63:0] r14_an, n14_an;
    logic [30:0] r14_ad, n14_ad;
    logic        r14_neg, n14_neg, r14_zero, n14_zero;

    logic [31:0] w_temp;
    logic [31:0] w_hv, w_hcl;
    logic [31:0] w_hs;

    always_comb begin
        n_fsb[0].rp   = i_in_word.raw_pressure;
        n_fsb[0].rh   = i_in_word.raw_humidity;
        n_fsb[0].temp = '0;
        n_fsb[0].hum  = '0;
        for (int k = 1; k < NUM_FRONT; k++) begin
            n_fsb[k] = r_fsb[k-1];
        end

        // S1..S4: fine temperature
        n1_a   = 32'(i_in_word.raw_temperature[19:3]) - (w_t1 << 1);
        n1_dt  = 32'(i_in_word.raw_temperature[19:4]) - w_t1;
        n2_ma  = r1_a * w_t2;
        n2_mdt = r1_dt * r1_dt;
        n3_va  = f_asr32(r2_ma, 6'd11);
        n3_m2  = f_asr32(r2_mdt, 6'd12) * w_t3;
        n4_tf  = r3_va + f_asr32(r3_m2, 6'd14);

        // S5: temperature result, path offsets
        w_temp        = f_asr32(r4_tf * 32'd5 + 32'd128, 6'd8);
        n_fsb[4].temp = w_temp;
        n5_v          = r4_tf - 32'd76800;
        n5_x1         = 64'($signed(r4_tf)) - 64'd128000;

        // S6
        n6_ha = f_asr32((32'(r_fsb[4].rh) << 14) - (w_h4 << 20) - (r5_v * w_h5)
                        + 32'd16384, 6'd15);
        n6_m6 = r5_v * w_h6;
        n6_m3 = r5_v * w_h3;
        n6_sq = f_pp(r5_x1, r5_x1);
        n6_a5 = f_pp(r5_x1, w_p5);
        n6_a2 = f_pp(r5_x1, w_p2);

        // S7
        n7_ha  = r6_ha;
        n7_hbm = f_asr32(r6_m6, 6'd10) * (f_asr32(r6_m3, 6'd11) + 32'd32768);
        n7_sq  = f_pp_sum(r6_sq);
        n7_a5  = f_pp_sum(r6_a5);
        n7_a2  = f_pp_sum(r6_a2);

        // S8
        n8_ha  = r7_ha;
        n8_hcm = (f_asr32(r7_hbm, 6'd10) + 32'd2097152) * w_h2;
        n8_b6  = f_pp(r7_sq, w_p6);
        n8_b3  = f_pp(r7_sq, w_p3);
        n8_a5  = r7_a5;
        n8_a2  = r7_a2;

        // S9
        n9_vv = r8_ha * f_asr32(r8_hcm + 32'd8192, 6'd14);
        n9_b6 = f_pp_sum(r8_b6);
        n9_b3 = f_pp_sum(r8_b3);
        n9_a5 = r8_a5;
        n9_a2 = r8_a2;

        // S10
        w_hs   = f_asr32(r9_vv, 6'd15);
        n10_vv = r9_vv;
        n10_sq = w_hs * w_hs;
        n10_x2 = r9_b6 + (r9_a5 << 17) + (w_p4 << 35);
        n10_y  = 64'h0000_8000_0000_0000 + f_asr64(r9_b3, 6'd8) + (r9_a2 << 12);

        // S11
        n11_vv = r10_vv;
        n11_m  = f_asr32(r10_sq, 6'd7) * w_h1;
        n11_py = f_pp(r10_y, w_p1);
        n11_n0 = ((64'd1048576 - 64'(r_fsb[9].rp)) << 31) - r10_x2;

        // S12: humidity clamp, divisor (fits 31 bits signed after the shift)
        w_hv = r11_vv - f_asr32(r11_m, 6'd4);
        if (w_hv[31]) begin
            w_hcl = '0;
        end else if (w_hv > HUM_MAX) begin
            w_hcl = HUM_MAX;
        end else begin
            w_hcl = w_hv;
        end
        n_fsb[11].hum = w_hcl[28:12];
        n12_den       = 32'(f_asr64(f_pp_sum(r11_py), 6'd33));
        n12_pn        = f_pp(r11_n0, 64'd3125);

        // S13
        n13_den = r12_den;
        n13_num = f_pp_sum(r12_pn);

        // S14: magnitudes and sign for the unsigned divider
        n14_an   = r13_num[63] ? (64'd0 - r13_num) : r13_num;
        n14_ad   = 31'(r13_den[31] ? (32'd0 - r13_den) : r13_den);
        n14_neg  = r13_num[63] ^ r13_den[31];
        n14_zero = (r13_den == 32'd0);
    end

    // ---------------- divider: one quotient bit per stage ----------------
    t_dv  r_dv  [DIV_STEPS];
    t_dv  n_dv  [DIV_STEPS];
    t_dsb r_dsb [DIV_STEPS];
    t_dsb n_dsb [DIV_STEPS];

    always_comb begin
        n_dv[0]       = f_div_step(31'd0, r14_an, r14_ad);
        n_dsb[0].temp = r_fsb[NUM_FRONT-1].temp;
        n_dsb[0].hum  = r_fsb[NUM_FRONT-1].hum;
        n_dsb[0].neg  = r14_neg;
        n_dsb[0].zero = r14_zero;
        n_dsb[0].ad   = r14_ad;
        for (int k = 1; k < DIV_STEPS; k++) begin
            n_dv[k]  = f_div_step(r_dv[k-1].rem, r_dv[k-1].q, r_dsb[k-1].ad);
            n_dsb[k] = r_dsb[k-1];
        end
    end

    // ---------------- back end: pressure correction ----------------
    t_bsb        r_bsb [NUM_BACK];
    t_bsb        n_bsb [NUM_BACK];
    logic [63:0] r_b1_p, n_b1_p;
    t_pp         r_b2_ss, n_b2_ss, r_b2_m8, n_b2_m8;
    logic [63:0] r_b2_p, n_b2_p;
    logic [63:0] r_b3_ss, n_b3_ss, r_b3_m8, n_b3_m8, r_b3_p, n_b3_p;
    t_pp         r_b4_t9, n_b4_t9;
    logic [63:0] r_b4_m8, n_b4_m8, r_b4_p, n_b4_p;
    logic [63:0] r_b5_t9, n_b5_t9, r_b5_m8, n_b5_m8, r_b5_p, n_b5_p;
    logic [31:0] r_b6_pq, n_b6_pq;
    logic [63:0] w_s, w_pq64;
    logic [31:0] w_pm;

    always_comb begin
        n_bsb[0].temp = r_dsb[DIV_STEPS-1].temp;
        n_bsb[0].hum  = r_dsb[DIV_STEPS-1].hum;
        n_bsb[0].zero = r_dsb[DIV_STEPS-1].zero;
        for (int k = 1; k < NUM_BACK; k++) begin
            n_bsb[k] = r_bsb[k-1];
        end

        n_b1_p = r_dsb[DIV_STEPS-1].neg ? (64'd0 - r_dv[DIV_STEPS-1].q)
                                        : r_dv[DIV_STEPS-1].q;

        w_s     = f_asr64(r_b1_p, 6'd13);
        n_b2_ss = f_pp(w_s, w_s);
        n_b2_m8 = f_pp(r_b1_p, w_p8);
        n_b2_p  = r_b1_p;

        n_b3_ss = f_pp_sum(r_b2_ss);
        n_b3_m8 = f_pp_sum(r_b2_m8);
        n_b3_p  = r_b2_p;

        n_b4_t9 = f_pp(r_b3_ss, w_p9);
        n_b4_m8 = r_b3_m8;
        n_b4_p  = r_b3_p;

        n_b5_t9 = f_pp_sum(r_b4_t9);
        n_b5_m8 = r_b4_m8;
        n_b5_p  = r_b4_p;

        // zero divisor forces a zero pressure
        w_pq64  = f_asr64(r_b5_p + f_asr64(r_b5_t9, 6'd25) + f_asr64(r_b5_m8, 6'd19), 6'd8)
                  + (w_p7 << 4);
        n_b6_pq = r_bsb[NUM_BACK-2].zero ? 32'd0 : w_pq64[31:0];

        // Q24.8 * 100 / 256, wrapping at 32 bits
        w_pm                    = r_b6_pq * 32'd100;
        w_res.temperature_centi = r_bsb[NUM_BACK-1].temp;
        w_res.pressure_scaled   = w_pm >> 8;
        w_res.humidity_q10      = r_bsb[NUM_BACK-1].hum;
    end

    // ---------------- stage registers (payload, no reset) ----------------
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fsb   <= n_fsb;
            r1_a    <= n1_a;    r1_dt  <= n1_dt;
            r2_ma   <= n2_ma;   r2_mdt <= n2_mdt;
            r3_va   <= n3_va;   r3_m2  <= n3_m2;
            r4_tf   <= n4_tf;
            r5_v    <= n5_v;    r5_x1  <= n5_x1;
            r6_ha   <= n6_ha;   r6_m6  <= n6_m6;  r6_m3 <= n6_m3;
            r6_sq   <= n6_sq;   r6_a5  <= n6_a5;  r6_a2 <= n6_a2;
            r7_ha   <= n7_ha;   r7_hbm <= n7_hbm;
            r7_sq   <= n7_sq;   r7_a5  <= n7_a5;  r7_a2 <= n7_a2;
            r8_ha   <= n8_ha;   r8_hcm <= n8_hcm;
            r8_b6   <= n8_b6;   r8_b3  <= n8_b3;  r8_a5 <= n8_a5; r8_a2 <= n8_a2;
            r9_vv   <= n9_vv;
            r9_b6   <= n9_b6;   r9_b3  <= n9_b3;  r9_a5 <= n9_a5; r9_a2 <= n9_a2;
            r10_vv  <= n10_vv;  r10_sq <= n10_sq;
            r10_x2  <= n10_x2;  r10_y  <= n10_y;
            r11_vv  <= n11_vv;  r11_m  <= n11_m;
            r11_py  <= n11_py;  r11_n0 <= n11_n0;
            r12_den <= n12_den; r12_pn <= n12_pn;
            r13_den <= n13_den; r13_num <= n13_num;
            r14_an  <= n14_an;  r14_ad <= n14_ad;
            r14_neg <= n14_neg; r14_zero <= n14_zero;
            r_dv    <= n_dv;
            r_dsb   <= n_dsb;
            r_bsb   <= n_bsb;
            r_b1_p  <= n_b1_p;
            r_b2_ss <= n_b2_ss; r_b2_m8 <= n_b2_m8; r_b2_p <= n_b2_p;
            r_b3_ss <= n_b3_ss; r_b3_m8 <= n_b3_m8; r_b3_p <= n_b3_p;
            r_b4_t9 <= n_b4_t9; r_b4_m8 <= n_b4_m8; r_b4_p <= n_b4_p;
            r_b5_t9 <= n_b5_t9; r_b5_m8 <= n_b5_m8; r_b5_p <= n_b5_p;
            r_b6_pq <= n_b6_pq;
        end
    end

    // ---------------- output word and skid ----------------
    always_comb begin
        n_out_v  = r_out_v;
        n_skid_v = r_skid_v;
        n_out    = r_out;
        n_skid   = r_skid;
        if (r_skid_v) begin
            // pipe frozen: drain skid into the output word
            if (!i_out_stall) begin
                n_out    = r_skid;
                n_skid_v = 1'b0;
            end
        end else if (r_vld[LAST]) begin
            if (!r_out_v || !i_out_stall) begin
                n_out   = w_res;
                n_out_v = 1'b1;
            end else begin
                n_skid   = w_res;
                n_skid_v = 1'b1;
            end
        end else if (r_out_v && !i_out_stall) begin
            n_out_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_vld    <= n_vld;
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid = r_out_v;
    assign o_out_word  = r_out;

    // ---------------- checks ----------------
    `ESC_ASSERT_NOW(a_skid_needs_out, r_skid_v, r_out_v, "skid word held without output word")
    `ESC_ASSERT_NEXT(a_accept_enters, i_in_valid && !o_in_stall, r_vld[0], "accepted word lost")
    `ESC_ASSERT_NEXT(a_stall_to_skid, r_vld[LAST] && !r_skid_v && r_out_v && i_out_stall, r_skid_v, "result dropped on stall")
    `ESC_ASSERT_NEXT(a_skid_freezes, r_skid_v && i_out_stall, r_skid_v && $stable(r_vld), "pipe moved while skid full")

endmodule
